// ===== rtl/core/cdf_pkg.sv =====
`default_nettype none

package cdf_pkg;

    localparam int VALUE_W = 8;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [2:0]         t_state;

    localparam t_state ST_LOAD   = 3'd0;
    localparam t_state ST_P1_S   = 3'd1;
    localparam t_state ST_P1_F1  = 3'd2;
    localparam t_state ST_P1_F2  = 3'd3;
    localparam t_state ST_P2_CHK = 3'd4;
    localparam t_state ST_P2_F   = 3'd5;
    localparam t_state ST_P2_S   = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/core/cdf_ram.sv =====
`default_nettype none

module cdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/cycle_detect_duplicate_find_top.sv =====
// duplicate finder by tortoise-and-hare cycle detection
//
// input channel (i_valid/o_ready): one array element per item in i_value;
// i_last marks the final element and closes the array. elements are loaded
// one per cycle, while o_ready is high, into the element memory.
// output channel (o_valid/i_ready): one result item per closing item, with
// o_duplicate the repeated value, or o_error set and o_duplicate zero when
// the array has fewer than two elements, a zero, a value not below the
// element count, or more than MAX_ENTRIES elements.
// a rejected array gives its result in the cycle after the closing item.
// otherwise the search runs on the one memory read port, each read waiting
// for the registered read data: three reads per first-phase step, two per
// second-phase step plus a compare state.
// o_ready is low during the search, and also for a closing item while an
// earlier result is still held; ordinary elements keep loading meanwhile.
// the output register holds a result until i_ready takes it.
// reset (synchronous, active low) empties the loader and the output; the
// element memory needs no clearing.
`default_nettype none

module cycle_detect_duplicate_find_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic [7:0] i_value,
    input  wire logic i_last,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [7:0] o_duplicate,
    output logic      o_error
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > cdf_pkg::VALUE_W) ? CW : cdf_pkg::VALUE_W;

    cdf_pkg::t_state r_state, n_state;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_count, n_count;
    cdf_pkg::t_value r_largest, n_largest;
    logic            r_flag, n_flag;
    cdf_pkg::t_value r_slow, n_slow;
    cdf_pkg::t_value r_fast, n_fast;
    logic            r_out_valid, n_out_valid;
    cdf_pkg::t_value r_dup, n_dup;
    logic            r_err, n_err;

    logic            accept;
    logic            room;
    logic            bad;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    cdf_pkg::t_value ram_rdata;

    assign accept  = i_valid && o_ready;
    assign room    = r_count < CW'(MAX_ENTRIES);
    assign ram_we  = accept && room;
    assign o_ready = (r_state == cdf_pkg::ST_LOAD) && !(r_out_valid && i_last);

    assign o_valid     = r_out_valid;
    assign o_duplicate = r_dup;
    assign o_error     = r_err;

    always_comb begin
        if (r_state == cdf_pkg::ST_P1_S || r_state == cdf_pkg::ST_P2_S) begin
            ram_raddr = AW'(r_slow);
        end else begin
            ram_raddr = AW'(r_fast);
        end
    end

    cdf_ram #(
        .WIDTH(cdf_pkg::VALUE_W),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_count     = r_count;
        n_largest   = r_largest;
        n_flag      = r_flag;
        n_slow      = r_slow;
        n_fast      = r_fast;
        n_out_valid = r_out_valid;
        n_dup       = r_dup;
        n_err       = r_err;
        bad         = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cdf_pkg::ST_LOAD: begin
                if (accept) begin
                    if (room) begin
                        n_count = r_count + CW'(1);
                        if (i_value == '0) begin
                            n_flag = 1'b1;
                        end
                        if (i_value > r_largest) begin
                            n_largest = i_value;
                        end
                    end else begin
                        n_flag = 1'b1;
                    end
                    if (i_last) begin
                        bad = (n_count < CW'(2)) || n_flag
                              || (CMPW'(n_largest) >= CMPW'(n_count));
                        if (bad) begin
                            n_out_valid = 1'b1;
                            n_dup       = '0;
                            n_err       = 1'b1;
                        end else begin
                            n_state = cdf_pkg::ST_P1_S;
                            n_slow  = '0;
                            n_fast  = '0;
                            n_pend  = 1'b0;
                        end
                        n_count   = '0;
                        n_largest = '0;
                        n_flag    = 1'b0;
                    end
                end
            end
            cdf_pkg::ST_P1_S: begin
                n_pend = !r_pend;
                if (r_pend) begin
                    n_slow  = ram_rdata;
                    n_state = cdf_pkg::ST_P1_F1;
                end
            end
            cdf_pkg::ST_P1_F1: begin
                n_pend = !r_pend;
                if (r_pend) begin
                    n_fast  = ram_rdata;
                    n_state = cdf_pkg::ST_P1_F2;
                end
            end
            cdf_pkg::ST_P1_F2: begin
                n_pend = !r_pend;
                if (r_pend) begin
                    if (ram_rdata == r_slow) begin
                        n_fast  = '0;
                        n_state = cdf_pkg::ST_P2_CHK;
                    end else begin
                        n_fast  = ram_rdata;
                        n_state = cdf_pkg::ST_P1_S;
                    end
                end
            end
            cdf_pkg::ST_P2_CHK: begin
                if (r_slow == r_fast) begin
                    n_out_valid = 1'b1;
                    n_dup       = r_slow;
                    n_err       = 1'b0;
                    n_state     = cdf_pkg::ST_LOAD;
                end else begin
                    n_state = cdf_pkg::ST_P2_F;
                end
            end
            cdf_pkg::ST_P2_F: begin
                n_pend = !r_pend;
                if (r_pend) begin
                    n_fast  = ram_rdata;
                    n_state = cdf_pkg::ST_P2_S;
                end
            end
            cdf_pkg::ST_P2_S: begin
                n_pend = !r_pend;
                if (r_pend) begin
                    n_slow  = ram_rdata;
                    n_state = cdf_pkg::ST_P2_CHK;
                end
            end
            default: begin
                n_state = cdf_pkg::ST_LOAD;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdf_pkg::ST_LOAD;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_largest   <= '0;
            r_flag      <= 1'b0;
            r_slow      <= '0;
            r_fast      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_largest   <= n_largest;
            r_flag      <= n_flag;
            r_slow      <= n_slow;
            r_fast      <= n_fast;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dup <= n_dup;
        r_err <= n_err;
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cdf_pkg::ST_LOAD) |-> !o_ready)
        else $error("ready while searching");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("load count past store depth");

    a_write_only_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == cdf_pkg::ST_LOAD))
        else $error("store written during search");

    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_error && o_duplicate == '0) || (!o_error && o_duplicate != '0)))
        else $error("result fields inconsistent");

    a_search_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdf_pkg::ST_P2_CHK && r_slow == r_fast) |=> o_valid)
        else $error("finished search gave no result");

endmodule

`default_nettype wire
